[rtl/lcs_pkg.sv]
// Package for the Lehmer cofactor step block: sizes, register map, sequencer
// states and the control/status structs passed between sequencer and datapath.
// No dependencies.
package lcs_pkg;

  localparam int DATA_BITS = 64;
  localparam int WORD_BITS_DEF = 64;
  localparam int ADDR_BITS = 4;
  localparam logic [DATA_BITS-1:0] STOP_RESET = 64'h0000_0001_0000_0000;

  // register index is paddr[3] (8-byte stride)
  localparam logic REG_STOP = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_ALIGN,
    ST_DIVIDE,
    ST_UPDATE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic prep;
    logic shift;
    logic step;
    logic update;
  } ctrl_t;

  typedef struct packed {
    logic v_zero;
    logic can_shift;
    logic stop;
  } stat_t;

endpackage

[rtl/lcs_apb_regs.sv]
// Configuration register file: holds the stop threshold behind an APB port.
// Depends on lcs_pkg.
module lcs_apb_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lcs_pkg::ADDR_BITS-1:0]  paddr,
  input  logic [lcs_pkg::DATA_BITS-1:0]  pwdata,
  output logic [lcs_pkg::DATA_BITS-1:0]  prdata,
  output logic                           pready,
  output logic [lcs_pkg::DATA_BITS-1:0]  stop_threshold
);
  import lcs_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[3] == REG_STOP);

  always_ff @(posedge clk) begin
    if (rst) begin
      stop_threshold <= STOP_RESET;
    end else if (wr_en) begin
      stop_threshold <= pwdata;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[3] == REG_STOP) begin
      prdata = stop_threshold;
    end
  end

endmodule

[rtl/lcs_dp.sv]
// Datapath: operand, remainder, divisor and cofactor registers around one
// shared compare/subtract/shift-add step. Driven by lcs_seq; depends on lcs_pkg.
module lcs_dp #(
  parameter int WORD_BITS = lcs_pkg::WORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic [lcs_pkg::DATA_BITS-1:0]  first_word,
  input  logic [lcs_pkg::DATA_BITS-1:0]  second_word,
  input  logic [lcs_pkg::DATA_BITS-1:0]  stop_threshold,
  input  lcs_pkg::ctrl_t                 ctrl,
  output lcs_pkg::stat_t                 stat,
  output logic signed [lcs_pkg::DATA_BITS-1:0] cof_a,
  output logic signed [lcs_pkg::DATA_BITS-1:0] cof_b,
  output logic signed [lcs_pkg::DATA_BITS-1:0] cof_c,
  output logic signed [lcs_pkg::DATA_BITS-1:0] cof_d
);
  import lcs_pkg::*;

  localparam int W = WORD_BITS;

  logic [W-1:0] in_u, in_v;
  logic [W-1:0] u, v, rem, dvs;
  logic [W-1:0] a, b, c, d;
  logic [W-1:0] acc_c, acc_d;
  logic         ge;

  assign in_u = first_word[W-1:0];
  assign in_v = second_word[W-1:0];
  assign ge   = (rem >= dvs);

  assign stat.v_zero    = (v == '0);
  assign stat.can_shift = !dvs[W-1] && ((dvs << 1) <= rem);
  assign stat.stop      = (rem == '0) || (DATA_BITS'(rem) < stop_threshold);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      if (in_u < in_v) begin
        u <= in_v;
        v <= in_u;
        a <= '0;
        b <= W'(1);
        c <= W'(1);
        d <= '0;
      end else begin
        u <= in_u;
        v <= in_v;
        a <= W'(1);
        b <= '0;
        c <= '0;
        d <= W'(1);
      end
    end
    if (ctrl.prep) begin
      rem   <= u;
      dvs   <= v;
      acc_c <= '0;
      acc_d <= '0;
    end
    if (ctrl.shift) begin
      dvs <= dvs << 1;
    end
    // one quotient bit, MSB first; products q*c and q*d build up by Horner
    if (ctrl.step) begin
      if (ge) begin
        rem <= rem - dvs;
      end
      acc_c <= (acc_c << 1) + (ge ? c : '0);
      acc_d <= (acc_d << 1) + (ge ? d : '0);
      dvs   <= dvs >> 1;
    end
    if (ctrl.update) begin
      u <= v;
      v <= rem;
      a <= c;
      b <= d;
      c <= a - acc_c;
      d <= b - acc_d;
    end
  end

  assign cof_a = DATA_BITS'(signed'(a));
  assign cof_b = DATA_BITS'(signed'(b));
  assign cof_c = DATA_BITS'(signed'(c));
  assign cof_d = DATA_BITS'(signed'(d));

endmodule

[rtl/lcs_seq.sv]
// Sequencer: steps the datapath through align, divide and update for each
// Euclid step and flags the finished word. Depends on lcs_pkg.
module lcs_seq #(
  parameter int WORD_BITS = lcs_pkg::WORD_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  lcs_pkg::stat_t stat,
  output lcs_pkg::ctrl_t ctrl,
  output logic           busy,
  output logic           done
);
  import lcs_pkg::*;

  localparam int KW = $clog2(WORD_BITS);

  state_t        state, state_next;
  logic [KW-1:0] k, k_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      k     <= '0;
    end else begin
      state <= state_next;
      k     <= k_next;
    end
  end

  always_comb begin
    state_next = state;
    k_next     = k;
    ctrl       = '0;
    done       = 1'b0;
    busy       = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (start) begin
          ctrl.load  = 1'b1;
          state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        if (stat.v_zero) begin
          state_next = ST_DONE;
        end else begin
          ctrl.prep  = 1'b1;
          k_next     = '0;
          state_next = ST_ALIGN;
        end
      end
      ST_ALIGN: begin
        // line the divisor up under the top of the remainder
        if (stat.can_shift) begin
          ctrl.shift = 1'b1;
          k_next     = k + KW'(1);
        end else begin
          state_next = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        ctrl.step = 1'b1;
        if (k == '0) begin
          state_next = ST_UPDATE;
        end else begin
          k_next = k - KW'(1);
        end
      end
      ST_UPDATE: begin
        ctrl.update = 1'b1;
        state_next  = stat.stop ? ST_DONE : ST_PREP;
      end
      ST_DONE: begin
        done       = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/lehmer_cofactor_step_top.sv]
// Lehmer cofactor step, top level. Per word the sequencer loads the operands, then
// runs prep, align shifts, divide steps and update for each Euclid step; a zero operand
// sends it from prep straight to done. All steps use the single shared radix-2
// divide/multiply-add unit. One word in flight: busy stays high through the result
// strobe and the next word can be taken the cycle after. done is high for one cycle
// and cannot be stalled. Reset: threshold to 2^32, sequencer idle.
module lehmer_cofactor_step_top #(
  parameter int WORD_BITS = lcs_pkg::WORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lcs_pkg::ADDR_BITS-1:0]  paddr,
  input  logic [lcs_pkg::DATA_BITS-1:0]  pwdata,
  output logic [lcs_pkg::DATA_BITS-1:0]  prdata,
  output logic                           pready,
  input  logic                           start,
  output logic                           busy,
  input  logic [lcs_pkg::DATA_BITS-1:0]  first_word,
  input  logic [lcs_pkg::DATA_BITS-1:0]  second_word,
  output logic                           done,
  output logic signed [lcs_pkg::DATA_BITS-1:0] cof_a,
  output logic signed [lcs_pkg::DATA_BITS-1:0] cof_b,
  output logic signed [lcs_pkg::DATA_BITS-1:0] cof_c,
  output logic signed [lcs_pkg::DATA_BITS-1:0] cof_d
);
  import lcs_pkg::*;

  logic [DATA_BITS-1:0] stop_threshold;
  ctrl_t                ctrl;
  stat_t                stat;
  logic                 seq_busy;

  assign busy = seq_busy;

  lcs_apb_regs u_regs (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .stop_threshold (stop_threshold)
  );

  lcs_seq #(.WORD_BITS(WORD_BITS)) u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .ctrl  (ctrl),
    .busy  (seq_busy),
    .done  (done)
  );

  lcs_dp #(.WORD_BITS(WORD_BITS)) u_dp (
    .clk            (clk),
    .first_word     (first_word),
    .second_word    (second_word),
    .stop_threshold (stop_threshold),
    .ctrl           (ctrl),
    .stat           (stat),
    .cof_a          (cof_a),
    .cof_b          (cof_b),
    .cof_c          (cof_c),
    .cof_d          (cof_d)
  );

endmodule

[tb/tb_top.sv]
// Self-checking bench for lehmer_cofactor_step_top: predicts the cofactor matrix per word
// and checks every result strobe against it, stepping the stop threshold between phases.
// Depends on rtl/lcs_pkg.sv and rtl/lehmer_cofactor_step_top.sv.
module tb_top;

  localparam int W = lcs_pkg::DATA_BITS;
  localparam int AW = lcs_pkg::ADDR_BITS;
  localparam logic [AW-1:0] ADDR_STOP = {lcs_pkg::REG_STOP, 3'b000};
  localparam logic [AW-1:0] ADDR_SPARE = {~lcs_pkg::REG_STOP, 3'b000};
  localparam logic [W-1:0] WORD_MAX = '1;
  localparam logic [W-1:0] SIGN_ONLY = 64'h8000_0000_0000_0000;
  localparam int IDLE_PCT = 38;
  localparam int STALL_LIMIT = 20000;

  typedef logic [W-1:0] word_t;

  typedef struct packed {
    word_t u;
    word_t v;
  } operand_pair_t;

  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
    word_t d;
  } cof_set_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [AW-1:0] paddr = '0;
  word_t pwdata = '0;
  word_t prdata;
  logic pready;
  logic start = 1'b0;
  logic busy;
  word_t first_word = '0;
  word_t second_word = '0;
  logic done;
  logic signed [W-1:0] cof_a, cof_b, cof_c, cof_d;

  operand_pair_t operand_q[$];
  cof_set_t matrix_q[$];
  word_t stop_level = lcs_pkg::STOP_RESET;
  int sent_count = 0;
  int mismatches = 0;
  int quiet_cycles = 0;

  lehmer_cofactor_step_top DUT (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .start(start), .busy(busy),
    .first_word(first_word), .second_word(second_word),
    .done(done), .cof_a(cof_a), .cof_b(cof_b), .cof_c(cof_c), .cof_d(cof_d)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Euclid reduction with the cofactor matrix carried alongside, wrapping mod 2^64
  function automatic cof_set_t lehmer_matrix(word_t op_u, word_t op_v, word_t stop);
    word_t u, v, q, r, t;
    cof_set_t m;
    u = op_u;
    v = op_v;
    if (u < v) begin
      u = op_v;
      v = op_u;
      m = '{64'd0, 64'd1, 64'd1, 64'd0};
    end else begin
      m = '{64'd1, 64'd0, 64'd0, 64'd1};
    end
    while (v != 0) begin
      q = u / v;
      r = u % v;
      u = v;
      v = r;
      t = m.a - q * m.c;
      m.a = m.c;
      m.c = t;
      t = m.b - q * m.d;
      m.b = m.d;
      m.d = t;
      if (v < stop) break;
    end
    return m;
  endfunction

  function automatic word_t rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic word_t corner_word();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return 64'd1;
      2: return WORD_MAX;
      3: return SIGN_ONLY;
      default: return rand64();
    endcase
  endfunction

  task automatic push_pair(input word_t u, input word_t v);
    operand_q.push_back('{u, v});
  endtask

  task automatic push_random(input int count);
    word_t u, v, f0, f1, t;
    int n;
    repeat (count) begin
      case ($urandom_range(0, 5))
        0: begin
          u = rand64();
          v = rand64();
        end
        1: begin
          u = rand64() >> $urandom_range(0, 63);
          v = rand64() >> $urandom_range(0, 63);
        end
        2: begin
          // steer the first quotient to a chosen size
          u = rand64();
          v = (u >> $urandom_range(1, 40)) + $urandom_range(0, 3);
        end
        3: begin
          u = rand64();
          v = u - $urandom_range(0, 1000);
        end
        4: begin
          // consecutive Fibonacci numbers give the longest chains of unit quotients
          f0 = '0;
          f1 = 64'd1;
          n = $urandom_range(2, 91);
          repeat (n) begin
            t = f0 + f1;
            f0 = f1;
            f1 = t;
          end
          u = f1;
          v = f0;
          if ($urandom_range(0, 1) == 1) begin
            u = f0;
            v = f1;
          end
        end
        default: begin
          u = corner_word();
          v = corner_word();
        end
      endcase
      push_pair(u, v);
    end
  endtask

  task automatic write_reg(input logic [AW-1:0] addr, input word_t value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_STOP) stop_level = value;
  endtask

  task automatic drain();
    while (operand_q.size() != 0 || matrix_q.size() != 0 || busy) @(posedge clk);
  endtask

  task automatic check_cofactor(input string name, input word_t want, input word_t got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, $signed(want), $signed(got));
      mismatches++;
    end
  endtask

  // driver: hold a word until accepted, else raise start at random, or always while sent_count is 200 to 299
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      first_word <= '0;
      second_word <= '0;
    end else begin
      if (start && !busy) begin
        matrix_q.push_back(lehmer_matrix(first_word, second_word, stop_level));
        void'(operand_q.pop_front());
        sent_count++;
      end
      if (!(start && busy)) begin
        if (operand_q.size() != 0 &&
            ((sent_count >= 200 && sent_count < 300) ||
             $urandom_range(0, 99) >= IDLE_PCT)) begin
          start <= 1'b1;
          first_word <= operand_q[0].u;
          second_word <= operand_q[0].v;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: a strobe lasts one cycle and cannot be held off
  always @(posedge clk) begin
    cof_set_t want;
    if (!rst && done) begin
      if (matrix_q.size() == 0) begin
        $error("result word with no expectation pending");
        mismatches++;
      end else begin
        want = matrix_q.pop_front();
        check_cofactor("cof_a", want.a, cof_a);
        check_cofactor("cof_b", want.b, cof_b);
        check_cofactor("cof_c", want.c, cof_c);
        check_cofactor("cof_d", want.d, cof_d);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset threshold: zero operands, swap, single big quotient, early stop
    push_pair('0, '0);
    push_pair(64'h123, '0);
    push_pair('0, 64'h123);
    push_pair(WORD_MAX, WORD_MAX);
    push_pair(WORD_MAX, 64'd1);
    push_pair(64'd1, WORD_MAX);
    push_pair(WORD_MAX, WORD_MAX - 1);
    push_pair(64'd7, 64'd7);
    push_pair(SIGN_ONLY, 64'd3);
    push_pair(64'd3, SIGN_ONLY);
    push_pair(64'd12200160415121876738, 64'd7540113804746346429);
    push_pair(64'h0000_0100_0000_0005, 64'h0000_0100_0000_0000);
    push_pair(WORD_MAX, 64'h0000_0001_0000_0000);
    push_pair(WORD_MAX, 64'h0000_0001_0000_0001);
    push_pair(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
    push_pair(64'd5, 64'd3);
    push_pair(64'd100, 64'd1);
    push_pair(SIGN_ONLY | 64'h0000_0002_0000_0000, 64'h0000_0002_0000_0001);
    drain();

    // nothing lives at the spare address: threshold must stay at reset
    write_reg(ADDR_SPARE, rand64());
    push_random(60);
    drain();

    // zero threshold: run to the end, with quotients large enough to wrap
    write_reg(ADDR_STOP, '0);
    push_pair(64'd12200160415121876738, 64'd7540113804746346429);
    push_pair(WORD_MAX, 64'd2);
    push_pair(WORD_MAX, 64'd3);
    push_pair(WORD_MAX, WORD_MAX - 1);
    push_pair(64'd1, WORD_MAX);
    push_random(80);
    drain();

    // full threshold: only the first step runs
    write_reg(ADDR_STOP, WORD_MAX);
    push_random(60);
    drain();

    write_reg(ADDR_STOP, 64'd1);
    push_random(50);
    drain();

    write_reg(ADDR_STOP, SIGN_ONLY);
    push_random(50);
    drain();

    repeat (4) begin
      write_reg(ADDR_STOP, rand64() >> $urandom_range(0, 63));
      push_random(50);
      drain();
    end

    write_reg(ADDR_STOP, lcs_pkg::STOP_RESET);
    push_random(30);
    drain();

    repeat (20) @(posedge clk);
    if (mismatches == 0 && matrix_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/lcs_pkg.sv
rtl/lcs_apb_regs.sv
rtl/lcs_dp.sv
rtl/lcs_seq.sv
rtl/lehmer_cofactor_step_top.sv
tb/tb_top.sv
